>>> src/cldf_pkg.sv
// types and constants shared by the chunked link receive deframer
package cldf_pkg;

   localparam logic [2:0] HEADER_BYTES = 3'd4;

   localparam logic       CSR_ACK_CODE  = 1'b0;
   localparam logic       CSR_MAX_CHUNK = 1'b1;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_DATA = 2'd1,
      PH_HALT = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_CHUNK    = 2'd1,
      ERR_OVERRUN  = 2'd2,
      ERR_NEGATIVE = 2'd3
   } error_type;

   typedef struct packed {
      logic [7:0] ack_code;
      logic [7:0] max_chunk;
   } config_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  chunk_left;
      logic [2:0]  header_count;
      logic [31:0] declared_length;
      logic [31:0] payload_count;
   } state_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       packet_end;
      logic       send_ack;
      logic       ack_received;
      error_type  error_code;
      logic       halted;
   } result_type;

endpackage

>>> src/cldf_core.sv
// next state and result for one received byte
module cldf_core
   import cldf_pkg::*;
(
   input  config_type cfg,
   input  state_type  cur,
   input  logic [7:0] rx_byte,
   output state_type  nxt,
   output result_type res
);

   logic        chunk_done;
   logic [31:0] len_or;

   always_comb begin
      nxt        = cur;
      res        = '0;
      chunk_done = 1'b0;
      len_or     = '0;
      case (cur.phase)
         PH_HALT: begin
            res.halted = 1'b1;
         end
         PH_LEN: begin
            if (rx_byte == cfg.ack_code) begin
               res.ack_received = 1'b1;
            end else if (rx_byte > cfg.max_chunk) begin
               res.error_code = ERR_CHUNK;
               res.halted     = 1'b1;
               nxt.phase      = PH_HALT;
            end else if (rx_byte == 8'd0) begin
               chunk_done = 1'b1;
            end else begin
               nxt.chunk_left = rx_byte;
               nxt.phase      = PH_DATA;
            end
         end
         PH_DATA: begin
            nxt.chunk_left = cur.chunk_left - 8'd1;
            if (cur.header_count < HEADER_BYTES) begin
               // little-endian length assembly
               len_or                = {24'd0, rx_byte} << {cur.header_count[1:0], 3'b000};
               nxt.declared_length   = cur.declared_length | len_or;
               nxt.header_count      = cur.header_count + 3'd1;
               if (nxt.header_count == HEADER_BYTES && nxt.declared_length[31]) begin
                  res.error_code = ERR_NEGATIVE;
                  res.halted     = 1'b1;
                  nxt.phase      = PH_HALT;
               end else begin
                  chunk_done = (nxt.chunk_left == 8'd0);
               end
            end else if (cur.payload_count >= cur.declared_length) begin
               res.error_code = ERR_OVERRUN;
               res.halted     = 1'b1;
               nxt.phase      = PH_HALT;
            end else begin
               res.payload_valid = 1'b1;
               res.payload_byte  = rx_byte;
               nxt.payload_count = cur.payload_count + 32'd1;
               chunk_done        = (nxt.chunk_left == 8'd0);
            end
         end
         default: begin
            res.halted = 1'b1;
            nxt.phase  = PH_HALT;
         end
      endcase

      if (chunk_done) begin
         res.send_ack = 1'b1;
         nxt.phase    = PH_LEN;
         if (nxt.header_count == HEADER_BYTES &&
             nxt.payload_count == nxt.declared_length) begin
            res.packet_end      = 1'b1;
            nxt.header_count    = '0;
            nxt.declared_length = '0;
            nxt.payload_count   = '0;
         end
      end
   end

endmodule

>>> src/cldf_out_buf.sv
// result register with a skid stage
module cldf_out_buf
   import cldf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_beat,
   input  result_type in_res,
   output logic       full,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_res
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_beat;
            main_in       = in_res;
         end
      end else if (in_beat) begin
         skid_valid_in = 1'b1;
         skid_in       = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;

endmodule

>>> src/chunked_link_receive_deframer.sv
// Chunked link receive deframer top level.
// One received byte per beat, one result beat per byte; a byte can be taken every cycle
// while req_stall is low, and its result is registered in the output buffer. The per-byte
// framing state (phase, chunk count, header count, length, payload count) updates when
// the byte is taken. A two-entry output buffer lets input continue while a result is
// stalled; input stalls only when both entries hold results. After an error the block
// reports halted on every later byte until reset.
module chunked_link_receive_deframer
   import cldf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_payload_valid,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_packet_end,
   output logic       rsp_send_ack,
   output logic       rsp_ack_received,
   output logic [1:0] rsp_error_code,
   output logic       rsp_halted
);

   config_type cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   state_type  state_nxt;
   result_type step_res;
   result_type out_res;
   logic       buf_full;
   logic       in_beat;

   assign req_stall = buf_full;
   assign in_beat   = req_valid && !buf_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ACK_CODE:  cfg_in.ack_code  = csr_data;
            CSR_MAX_CHUNK: cfg_in.max_chunk = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   assign state_in = in_beat ? state_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_code  <= 8'd255;
         cfg_ff.max_chunk <= 8'd31;
         state_ff         <= '{phase: PH_LEN, default: '0};
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

   cldf_core u_core (
      .cfg     (cfg_ff),
      .cur     (state_ff),
      .rx_byte (req_rx_byte),
      .nxt     (state_nxt),
      .res     (step_res)
   );

   cldf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_beat   (in_beat),
      .in_res    (step_res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (out_res)
   );

   assign rsp_payload_valid = out_res.payload_valid;
   assign rsp_payload_byte  = out_res.payload_byte;
   assign rsp_packet_end    = out_res.packet_end;
   assign rsp_send_ack      = out_res.send_ack;
   assign rsp_ack_received  = out_res.ack_received;
   assign rsp_error_code    = out_res.error_code;
   assign rsp_halted        = out_res.halted;

endmodule
